/* hdl/sha512c_pkg.sv */
`timescale 1ns / 1ps

package sha512c_pkg;

  typedef logic [63:0] word_t;
  typedef word_t [7:0] vars_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CVRD,
    ST_ROUND,
    ST_CVWR,
    ST_OUTRD,
    ST_OUTV
  } state_t;

  localparam logic [6:0] LAST_ROUND   = 7'd79;
  localparam logic [3:0] LAST_WORD    = 4'd15;
  localparam logic [3:0] STEP_LAST    = 4'd8;
  localparam logic [3:0] DIGEST_MIN   = 4'd6;
  localparam logic [3:0] DIGEST_MAX   = 4'd8;
  localparam logic [3:0] DIGEST_RESET = 4'd8;

  localparam logic REG_DIGEST_WORDS = 1'b0;

  localparam word_t ROUND_K [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam word_t INIT_HASH [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

endpackage

/* hdl/sha512_compression_core.sv */
`timescale 1ns / 1ps
// Block of 16 words: the words are accepted in ST_LOAD, then ST_CVRD loads the chaining
// value, 80 rounds run at one per cycle in ST_ROUND, and ST_CVWR updates the chaining value.
// Last block: after ST_CVWR each digest word is read in ST_OUTRD, then offered with out_valid
// in ST_OUTV; up to 15 words of the next message are taken during digest output.
// Synchronous reset clears control; chaining value reads back as the initial hash
// through per-entry valid flags, so no clearing pass is needed.

module sha512_compression_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] message_word,
  input  logic        final_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sha512c_pkg::state_t state, state_next;

  logic [3:0] word_count;
  logic       final_q;
  logic [3:0] cnt;
  logic [6:0] rnd;
  logic [2:0] out_idx;
  logic [3:0] digest_words;
  logic [7:0] cv_valid;
  logic [2:0] cv_addr_q;
  logic       cv_valid_q;

  sha512c_pkg::vars_t v, v_round;
  sha512c_pkg::word_t w_cur, w_prev, x16, w_new;
  sha512c_pkg::word_t cv_ram_a, cv_rd, cv_wdata;
  sha512c_pkg::word_t wa, wb, sw_wdata;

  logic       in_accept, out_accept, cfg_write;
  logic [3:0] n_words;
  logic       cv_we;
  logic [2:0] cv_waddr, cv_raddr;
  logic       sw_we;
  logic [3:0] sw_waddr, sa, sb;
  logic [6:0] d;

  assign in_accept  = in_valid & in_ready;
  assign out_accept = out_valid & out_ready;
  assign cfg_write  = psel & penable & pwrite & pready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == sha512c_pkg::REG_DIGEST_WORDS) ? {28'd0, digest_words} : 32'd0;

  always_comb begin
    if (digest_words < sha512c_pkg::DIGEST_MIN) begin
      n_words = sha512c_pkg::DIGEST_MIN;
    end else if (digest_words > sha512c_pkg::DIGEST_MAX) begin
      n_words = sha512c_pkg::DIGEST_MAX;
    end else begin
      n_words = digest_words;
    end
  end

  assign word_index = out_idx;
  assign last_word  = (out_idx == 3'(n_words - 4'd1));

  // chaining value store
  assign cv_raddr = cnt[2:0];
  assign cv_rd    = cv_valid_q ? cv_ram_a : sha512c_pkg::INIT_HASH[cv_addr_q];
  assign cv_we    = (state == sha512c_pkg::ST_CVWR) && (cnt != 4'd0);
  assign cv_waddr = 3'(cnt - 4'd1);
  assign cv_wdata = cv_rd + v[0];

  sha512c_ram #(.WIDTH(64), .DEPTH(8)) u_cv_ram (
    .clk     (clk),
    .we      (cv_we),
    .waddr   (cv_waddr),
    .wdata   (cv_wdata),
    .raddr_a (cv_raddr),
    .rdata_a (cv_ram_a),
    .raddr_b (out_idx),
    .rdata_b (digest_word)
  );

  // schedule window: reads are issued one round ahead
  assign d = rnd + 7'd1;

  always_comb begin
    sa = 4'd0;
    sb = 4'd0;
    if (state == sha512c_pkg::ST_CVRD) begin
      sa = (cnt == sha512c_pkg::STEP_LAST) ? 4'd1 : 4'd0;
    end else if (state == sha512c_pkg::ST_ROUND) begin
      sa = (d < 7'd15) ? 4'(d[3:0] + 4'd1) : 4'(d[3:0] - 4'd14);
      sb = (d == 7'd14) ? 4'd0 : 4'(d[3:0] - 4'd6);
    end
  end

  always_comb begin
    if (state == sha512c_pkg::ST_ROUND) begin
      sw_we    = (rnd >= 7'd15) && (rnd < sha512c_pkg::LAST_ROUND);
      sw_waddr = 4'(rnd[3:0] + 4'd1);
      sw_wdata = w_new;
    end else begin
      sw_we    = in_accept;
      sw_waddr = word_count;
      sw_wdata = message_word;
    end
  end

  sha512c_ram #(.WIDTH(64), .DEPTH(16)) u_sched_ram (
    .clk     (clk),
    .we      (sw_we),
    .waddr   (sw_waddr),
    .wdata   (sw_wdata),
    .raddr_a (sa),
    .rdata_a (wa),
    .raddr_b (sb),
    .rdata_b (wb)
  );

  sha512c_sched u_sched (
    .x16 (x16),
    .x15 (wa),
    .x7  (wb),
    .x2  (w_prev),
    .w   (w_new)
  );

  sha512c_round u_round (
    .v      (v),
    .w      (w_cur),
    .k      (sha512c_pkg::ROUND_K[rnd]),
    .v_next (v_round)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha512c_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      sha512c_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid && word_count == sha512c_pkg::LAST_WORD) begin
          state_next = sha512c_pkg::ST_CVRD;
        end
      end
      sha512c_pkg::ST_CVRD: begin
        if (cnt == sha512c_pkg::STEP_LAST) begin
          state_next = sha512c_pkg::ST_ROUND;
        end
      end
      sha512c_pkg::ST_ROUND: begin
        if (rnd == sha512c_pkg::LAST_ROUND) begin
          state_next = sha512c_pkg::ST_CVWR;
        end
      end
      sha512c_pkg::ST_CVWR: begin
        if (cnt == sha512c_pkg::STEP_LAST) begin
          state_next = final_q ? sha512c_pkg::ST_OUTRD : sha512c_pkg::ST_LOAD;
        end
      end
      sha512c_pkg::ST_OUTRD: begin
        in_ready   = (word_count != sha512c_pkg::LAST_WORD);
        state_next = sha512c_pkg::ST_OUTV;
      end
      sha512c_pkg::ST_OUTV: begin
        in_ready  = (word_count != sha512c_pkg::LAST_WORD);
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = last_word ? sha512c_pkg::ST_LOAD : sha512c_pkg::ST_OUTRD;
        end
      end
      default: begin
        state_next = sha512c_pkg::ST_LOAD;
      end
    endcase
  end

  // control counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      word_count   <= 4'd0;
      final_q      <= 1'b0;
      cnt          <= 4'd0;
      rnd          <= 7'd0;
      out_idx      <= 3'd0;
      digest_words <= sha512c_pkg::DIGEST_RESET;
      cv_valid     <= 8'd0;
    end else begin
      if (in_accept) begin
        word_count <= word_count + 4'd1;
        if (word_count == sha512c_pkg::LAST_WORD) begin
          final_q <= final_block;
        end
      end
      if (state == sha512c_pkg::ST_CVRD || state == sha512c_pkg::ST_CVWR) begin
        cnt <= (cnt == sha512c_pkg::STEP_LAST) ? 4'd0 : cnt + 4'd1;
      end else begin
        cnt <= 4'd0;
      end
      if (state == sha512c_pkg::ST_ROUND) begin
        rnd <= (rnd == sha512c_pkg::LAST_ROUND) ? 7'd0 : rnd + 7'd1;
      end
      if (cfg_write && paddr[2] == sha512c_pkg::REG_DIGEST_WORDS) begin
        digest_words <= pwdata[3:0];
      end
      if (cv_we) begin
        cv_valid[cv_waddr] <= 1'b1;
      end
      if (out_accept) begin
        if (last_word) begin
          out_idx  <= 3'd0;
          cv_valid <= 8'd0;
        end else begin
          out_idx <= out_idx + 3'd1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cv_addr_q  <= cv_raddr;
    cv_valid_q <= cv_valid[cv_raddr];
    unique case (state)
      sha512c_pkg::ST_CVRD: begin
        if (cnt != 4'd0) begin
          v <= {cv_rd, v[7:1]};
        end
        if (cnt == sha512c_pkg::STEP_LAST) begin
          w_cur <= wa;
        end
      end
      sha512c_pkg::ST_ROUND: begin
        v      <= v_round;
        w_cur  <= (rnd < 7'd15) ? wa : w_new;
        w_prev <= w_cur;
        x16    <= (rnd == 7'd14) ? wb : wa;
      end
      sha512c_pkg::ST_CVWR: begin
        if (cnt != 4'd0) begin
          v <= {v[7], v[7:1]};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* hdl/sha512c_ram.sv */
`timescale 1ns / 1ps

module sha512c_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* hdl/sha512c_sched.sv */
`timescale 1ns / 1ps

module sha512c_sched (
  input  sha512c_pkg::word_t x16,
  input  sha512c_pkg::word_t x15,
  input  sha512c_pkg::word_t x7,
  input  sha512c_pkg::word_t x2,
  output sha512c_pkg::word_t w
);

  assign w = x16 + sha512c_pkg::small_sigma0(x15) + x7 + sha512c_pkg::small_sigma1(x2);

endmodule

/* hdl/sha512c_round.sv */
`timescale 1ns / 1ps

module sha512c_round (
  input  sha512c_pkg::vars_t v,
  input  sha512c_pkg::word_t w,
  input  sha512c_pkg::word_t k,
  output sha512c_pkg::vars_t v_next
);

  sha512c_pkg::word_t ch;
  sha512c_pkg::word_t maj;
  sha512c_pkg::word_t t1;
  sha512c_pkg::word_t t2;

  always_comb begin
    ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1  = v[7] + sha512c_pkg::big_sigma1(v[4]) + ch + k + w;
    t2  = sha512c_pkg::big_sigma0(v[0]) + maj;
    v_next[0] = t1 + t2;
    v_next[1] = v[0];
    v_next[2] = v[1];
    v_next[3] = v[2];
    v_next[4] = v[3] + t1;
    v_next[5] = v[4];
    v_next[6] = v[5];
    v_next[7] = v[6];
  end

endmodule

/* hdl/sha512c_checker.sv */
`timescale 1ns / 1ps

module sha512c_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
    else $error("digest word changed while stalled");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_word |=> ##1
      (out_valid && word_index == 3'($past(word_index, 2) + 3'd1)))
    else $error("digest index did not advance by one");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_word |-> (word_index == 3'd5 || word_index == 3'd6 ||
                                word_index == 3'd7))
    else $error("digest ended before six words");

  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_word |=> !out_valid && in_ready)
    else $error("block not ready for words after digest");

endmodule

bind sha512_compression_core sha512c_checker u_sha512c_checker (.*);
